// ===== rtl/core/strip_profile_peak_detector_top_macros.svh =====
// ----------------------------------------------------------------------------
// Strip profile peak detector assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef STRIP_PROFILE_PEAK_DETECTOR_TOP_MACROS_SVH
`define STRIP_PROFILE_PEAK_DETECTOR_TOP_MACROS_SVH

// An antecedent that must always bring its consequent in the same cycle.
`define SPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must never hold.
`define SPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants shared by the strip profile peak detector modules.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int ROW_W      = 12;
  localparam int VAL_W      = 9;
  localparam int SUM_W      = 20;
  localparam int SW_W       = 13;
  localparam int HW_W       = 6;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_W      = 13;

  localparam int STRIP_MAX_DEF       = 4096;
  localparam int HALF_WINDOW_MAX_DEF = 32;
  localparam int ROWS_MAX_DEF        = 4096;

  localparam int QUEUE_DEPTH = 4;
  localparam int RES_DEPTH   = 4;

  localparam logic [VAL_W-1:0] VAL_FULL      = 9'd256;
  localparam logic [VAL_W-1:0] VAL_MIN_RESET = 9'd255;
  localparam logic [SW_W-1:0]  SW_RESET      = 13'd64;
  localparam logic [HW_W-1:0]  HW_RESET      = 6'd5;

  typedef enum logic [0:0] {
    CFG_STRIP_WIDTH = 1'b0,
    CFG_HALF_WINDOW = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PEAK    = 2'd0,
    KIND_VALLEY  = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  // One finished row travelling from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             store;
    logic             img;
  } row_ent_t;

  typedef struct packed {
    kind_e            kind;
    logic [ROW_W-1:0] peak_row;
    logic [VAL_W-1:0] peak_value;
    logic [ROW_W-1:0] valley_row;
    logic [VAL_W-1:0] valley_value;
    logic [ROW_W-1:0] rise_row;
    logic [VAL_W-1:0] rise_value;
    logic [ROW_W-1:0] fall_row;
    logic [VAL_W-1:0] fall_value;
    logic             last;
  } res_t;

endpackage

// ===== rtl/core/spd_fifo.sv =====
// ----------------------------------------------------------------------------
// spd_fifo
// Small synchronous first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module spd_fifo
  import spd_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] dout_o,
  output logic         empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rp_q];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= inc(wp_q);
      end
      if (do_pop) begin
        rp_q <= inc(rp_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/spd_div.sv =====
// ----------------------------------------------------------------------------
// spd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spd_div
  import spd_pkg::*;
#(
  parameter int NW = SUM_W,
  parameter int DW = DIV_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, dv_q, rem_n;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   sh, diff;
  logic          ge;

  assign sh     = {rem_q, quo_q[NW-1]};
  assign ge     = sh >= {1'b0, dv_q};
  assign diff   = sh - {1'b0, dv_q};
  assign rem_n  = ge ? diff[DW-1:0] : sh[DW-1:0];
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/spd_front.sv =====
// ----------------------------------------------------------------------------
// spd_front
// Pixel accumulator: sums each row and queues finished rows for the back.
// ----------------------------------------------------------------------------
module spd_front
  import spd_pkg::*;
#(
  parameter int ROWS_MAX = ROWS_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] pixel_i,
  input  logic       row_end_i,
  input  logic       image_end_i,
  output logic       q_push_o,
  output row_ent_t   q_ent_o
);

  localparam int RC_W = $clog2(ROWS_MAX + 1);

  logic [SUM_W-1:0] sum_q;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_n;
  logic [RC_W-1:0]  rows_q;
  logic             ends, store;

  assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(pixel_i);
  assign sum_n    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign ends     = row_end_i || image_end_i;
  assign store    = (rows_q < RC_W'(ROWS_MAX));

  assign q_push_o      = accept_i && ends && (store || image_end_i);
  assign q_ent_o.sum   = sum_n;
  assign q_ent_o.store = store;
  assign q_ent_o.img   = image_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      rows_q <= '0;
    end else if (accept_i) begin
      if (ends) begin
        sum_q <= '0;
        if (image_end_i) begin
          rows_q <= '0;
        end else if (store) begin
          rows_q <= rows_q + RC_W'(1);
        end
      end else begin
        sum_q <= sum_n;
      end
    end
  end

endmodule

// ===== rtl/core/spd_back.sv =====
// ----------------------------------------------------------------------------
// spd_back
// Row sequencer: profile value, ring store, moving window and peak search.
// ----------------------------------------------------------------------------
module spd_back
  import spd_pkg::*;
#(
  parameter int STRIP_MAX       = STRIP_MAX_DEF,
  parameter int HALF_WINDOW_MAX = HALF_WINDOW_MAX_DEF,
  parameter int ROWS_MAX        = ROWS_MAX_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  row_ent_t        q_ent_i,
  output logic            q_pop_o,
  input  logic [SW_W-1:0] strip_width_i,
  input  logic [HW_W-1:0] half_window_i,
  input  logic            res_full_i,
  output logic            res_push_o,
  output res_t            res_o
);

  localparam int D     = 2 * HALF_WINDOW_MAX + 1;
  localparam int PTR_W = $clog2(D);
  localparam int WIN_W = $clog2(HALF_WINDOW_MAX + 1);
  localparam int WS_W  = $clog2(2 * HALF_WINDOW_MAX * 256 + 1);
  localparam int CNT_W = $clog2(D);
  localparam int RC_W  = $clog2(ROWS_MAX + 1);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_DIVY  = 13'b0000000000010,
    ST_STORE = 13'b0000000000100,
    ST_RSUB  = 13'b0000000001000,
    ST_RCHK  = 13'b0000000010000,
    ST_ARD   = 13'b0000000100000,
    ST_ADIV  = 13'b0000001000000,
    ST_ADEC  = 13'b0000010000000,
    ST_AEMIT = 13'b0000100000000,
    ST_FINIT = 13'b0001000000000,
    ST_FCHK  = 13'b0010000000000,
    ST_FSUB  = 13'b0100000000000,
    ST_SUMM  = 13'b1000000000000
  } state_e;

  state_e st_q;
  row_ent_t ent_q;

  logic [VAL_W-1:0] ring_q [D];
  logic [VAL_W-1:0] rd_q;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;

  logic [RC_W-1:0]  rc_q, r_q, ai_q;
  logic [PTR_W-1:0] wptr_q, rptr_q, aip_q;
  logic [WIN_W-1:0] win_q, w_e, hw_clamp, k_fl;
  logic [WS_W-1:0]  wsum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [VAL_W-1:0] y_q;
  logic             seek_q, have_q, flush_q, atlast_q;
  logic [RC_W-1:0]  pr_q, vr_q, rr_q;
  logic [VAL_W-1:0] pv_q, vv_q, rv_q, minv_q, maxv_q;
  res_t             rec_q;

  logic             div_start, div_done;
  logic [SUM_W-1:0] div_a, div_quo, avg;
  logic [DIV_W-1:0] div_b, sw_eff;
  logic [VAL_W-1:0] y_new;

  logic [RC_W-1:0]  pr_e, vr_e, rr_e;
  logic [VAL_W-1:0] pv_e, vv_e, rv_e, y_a;
  logic             gt_avg, lt_avg;

  logic [RC_W-1:0]  pr_d, vr_d, rr_d;
  logic [VAL_W-1:0] pv_d, vv_d, rv_d;
  res_t             dec_rec, summ_rec;
  logic             dec_emit, dec_seek, dec_have, step_adv;
  state_e           step_next;

  function automatic logic [PTR_W-1:0] mod_sub(input logic [PTR_W-1:0] p,
                                               input logic [WIN_W:0]   k);
    logic [PTR_W:0] t;
    t = {1'b0, p} - (PTR_W+1)'(k);
    if (t[PTR_W]) begin
      t = t + (PTR_W+1)'(D);
    end
    return t[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(D - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ROW_W-1:0] row_out(input logic [RC_W-1:0] r);
    return ROW_W'(r);
  endfunction

  // Effective divisor and latched half window.
  always_comb begin
    sw_eff = DIV_W'(strip_width_i);
    if (strip_width_i == '0) begin
      sw_eff = DIV_W'(1);
    end else if (32'(strip_width_i) > STRIP_MAX) begin
      sw_eff = DIV_W'(STRIP_MAX);
    end
    hw_clamp = WIN_W'(half_window_i);
    if (half_window_i == '0) begin
      hw_clamp = WIN_W'(1);
    end else if (32'(half_window_i) > HALF_WINDOW_MAX) begin
      hw_clamp = WIN_W'(HALF_WINDOW_MAX);
    end
    w_e  = (rc_q == '0) ? hw_clamp : win_q;
    k_fl = (rc_q < RC_W'(win_q)) ? WIN_W'(rc_q) : win_q;
  end

  assign q_pop_o   = (st_q == ST_IDLE) && !q_empty_i;
  assign div_start = (q_pop_o && q_ent_i.store) || (st_q == ST_ARD);
  assign div_a     = (st_q == ST_ARD) ? SUM_W'(wsum_q) : q_ent_i.sum;
  assign div_b     = (st_q == ST_ARD) ? DIV_W'(cnt_q) : sw_eff;
  assign y_new     = (div_quo >= SUM_W'(256)) ? '0 :
                     VAL_FULL - {1'b0, div_quo[7:0]};

  spd_div #(.NW(SUM_W), .DW(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // Ring read port.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = aip_q;
    case (st_q)
      ST_STORE: begin
        rd_en   = (rc_q >= RC_W'({w_e, 1'b0}));
        rd_addr = mod_sub(wptr_q, {w_e, 1'b0});
      end
      ST_FCHK: begin
        rd_en   = (ai_q >= RC_W'(win_q));
        rd_addr = mod_sub(aip_q, {1'b0, win_q});
      end
      ST_ARD: begin
        rd_en   = 1'b1;
        rd_addr = aip_q;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = aip_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_STORE) begin
      ring_q[wptr_q] <= y_q;
    end
    if (rd_en) begin
      rd_q <= ring_q[rd_addr];
    end
  end

  // Trackers as seen by the analysis step; row zero restarts them.
  always_comb begin
    y_a    = rd_q;
    avg    = (cnt_q == '0) ? '0 : div_quo;
    gt_avg = SUM_W'(y_a) > avg;
    lt_avg = SUM_W'(y_a) < avg;
    if (ai_q == '0) begin
      pr_e = '0; vr_e = '0; rr_e = '0;
      pv_e = y_a; vv_e = y_a; rv_e = y_a;
    end else begin
      pr_e = pr_q; vr_e = vr_q; rr_e = rr_q;
      pv_e = pv_q; vv_e = vv_q; rv_e = rv_q;
    end
  end

  // Outcome of one analysis step: tracker updates and the record it may emit.
  always_comb begin
    dec_rec      = '0;
    dec_rec.last = !flush_q && !ent_q.img;
    dec_emit     = 1'b0;
    dec_seek     = seek_q;
    dec_have     = have_q;
    pr_d = pr_e; pv_d = pv_e;
    vr_d = vr_e; vv_d = vv_e;
    rr_d = rr_e; rv_d = rv_e;
    if (!seek_q) begin
      if (gt_avg || atlast_q) begin
        dec_rec.kind         = KIND_VALLEY;
        dec_rec.valley_row   = row_out(vr_e);
        dec_rec.valley_value = vv_e;
        dec_emit = have_q;
        dec_seek = 1'b1;
        rr_d = ai_q; rv_d = y_a;
        pr_d = ai_q; pv_d = y_a;
      end else if (y_a < vv_e) begin
        vr_d = ai_q; vv_d = y_a;
      end
    end else begin
      if (lt_avg) begin
        dec_rec.kind         = KIND_PEAK;
        dec_rec.peak_row     = row_out(pr_e);
        dec_rec.peak_value   = pv_e;
        dec_rec.valley_row   = row_out(vr_e);
        dec_rec.valley_value = vv_e;
        dec_rec.rise_row     = row_out(rr_e);
        dec_rec.rise_value   = rv_e;
        dec_rec.fall_row     = row_out(ai_q);
        dec_rec.fall_value   = y_a;
        dec_emit = 1'b1;
        dec_have = 1'b1;
        dec_seek = 1'b0;
        vr_d = ai_q; vv_d = y_a;
      end else if (y_a > pv_e) begin
        pr_d = ai_q; pv_d = y_a;
      end
    end
    step_next = flush_q ? (atlast_q ? ST_SUMM : ST_FCHK)
                        : (ent_q.img ? ST_FINIT : ST_IDLE);
    step_adv  = flush_q && !atlast_q;

    summ_rec              = '0;
    summ_rec.kind         = KIND_SUMMARY;
    summ_rec.peak_value   = maxv_q;
    summ_rec.valley_value = minv_q;
    summ_rec.last         = 1'b1;
  end

  // In the summary state a flush record may still sit in rec_q until the summary record replaces it.
  assign res_push_o = ((st_q == ST_AEMIT) ||
                       ((st_q == ST_SUMM) && (rec_q.kind == KIND_SUMMARY))) &&
                      !res_full_i;
  assign res_o      = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ent_q    <= '0;
      rc_q     <= '0;
      r_q      <= '0;
      ai_q     <= '0;
      wptr_q   <= '0;
      rptr_q   <= '0;
      aip_q    <= '0;
      win_q    <= WIN_W'(5);
      wsum_q   <= '0;
      cnt_q    <= '0;
      y_q      <= '0;
      seek_q   <= 1'b0;
      have_q   <= 1'b0;
      flush_q  <= 1'b0;
      atlast_q <= 1'b0;
      pr_q     <= '0;
      pv_q     <= '0;
      vr_q     <= '0;
      vv_q     <= '0;
      rr_q     <= '0;
      rv_q     <= '0;
      minv_q   <= VAL_MIN_RESET;
      maxv_q   <= '0;
      rec_q    <= '0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            ent_q <= q_ent_i;
            st_q  <= q_ent_i.store ? ST_DIVY : ST_FINIT;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            y_q  <= y_new;
            st_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          win_q  <= w_e;
          if (y_q < minv_q) minv_q <= y_q;
          if (y_q > maxv_q) maxv_q <= y_q;
          wsum_q <= wsum_q + WS_W'(y_q);
          cnt_q  <= cnt_q + CNT_W'(1);
          r_q    <= rc_q;
          rptr_q <= wptr_q;
          rc_q   <= rc_q + RC_W'(1);
          wptr_q <= inc(wptr_q);
          st_q   <= rd_en ? ST_RSUB : ST_RCHK;
        end
        ST_RSUB: begin
          wsum_q <= wsum_q - WS_W'(rd_q);
          cnt_q  <= cnt_q - CNT_W'(1);
          st_q   <= ST_RCHK;
        end
        ST_RCHK: begin
          if (r_q >= RC_W'(win_q)) begin
            ai_q     <= r_q - RC_W'(win_q);
            aip_q    <= mod_sub(rptr_q, {1'b0, win_q});
            flush_q  <= 1'b0;
            atlast_q <= 1'b0;
            st_q     <= ST_ARD;
          end else begin
            st_q <= ent_q.img ? ST_FINIT : ST_IDLE;
          end
        end
        ST_ARD: begin
          st_q <= ST_ADIV;
        end
        ST_ADIV: begin
          if (div_done) begin
            st_q <= ST_ADEC;
          end
        end
        ST_ADEC: begin
          pr_q   <= pr_d; pv_q <= pv_d;
          vr_q   <= vr_d; vv_q <= vv_d;
          rr_q   <= rr_d; rv_q <= rv_d;
          seek_q <= dec_seek;
          have_q <= dec_have;
          rec_q  <= dec_rec;
          if (dec_emit) begin
            st_q <= ST_AEMIT;
          end else begin
            st_q <= step_next;
            if (step_adv) begin
              ai_q  <= ai_q + RC_W'(1);
              aip_q <= inc(aip_q);
            end
          end
        end
        ST_AEMIT: begin
          if (!res_full_i) begin
            st_q <= step_next;
            if (step_adv) begin
              ai_q  <= ai_q + RC_W'(1);
              aip_q <= inc(aip_q);
            end
          end
        end
        ST_FINIT: begin
          rec_q <= summ_rec;
          if (rc_q == '0) begin
            st_q <= ST_SUMM;
          end else begin
            ai_q    <= rc_q - RC_W'(k_fl);
            aip_q   <= mod_sub(wptr_q, {1'b0, k_fl});
            flush_q <= 1'b1;
            st_q    <= ST_FCHK;
          end
        end
        ST_FCHK: begin
          atlast_q <= (ai_q == rc_q - RC_W'(1));
          st_q     <= rd_en ? ST_FSUB : ST_ARD;
        end
        ST_FSUB: begin
          wsum_q <= wsum_q - WS_W'(rd_q);
          cnt_q  <= cnt_q - CNT_W'(1);
          st_q   <= ST_ARD;
        end
        ST_SUMM: begin
          // The summary record is rebuilt here since flush records reuse rec_q.
          rec_q <= summ_rec;
          if (!res_full_i && rec_q.kind == KIND_SUMMARY) begin
            rc_q     <= '0;
            wptr_q   <= '0;
            wsum_q   <= '0;
            cnt_q    <= '0;
            seek_q   <= 1'b0;
            have_q   <= 1'b0;
            flush_q  <= 1'b0;
            atlast_q <= 1'b0;
            pr_q <= '0; pv_q <= '0;
            vr_q <= '0; vv_q <= '0;
            rr_q <= '0; rv_q <= '0;
            minv_q <= VAL_MIN_RESET;
            maxv_q <= '0;
            st_q   <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/strip_profile_peak_detector_top.sv =====
// ----------------------------------------------------------------------------
// strip_profile_peak_detector_top
// Row darkness profile of an image strip with moving-average peak search.
// ----------------------------------------------------------------------------
// Pixels are taken one beat per cycle while the four-entry row queue has a
// free slot; once it is full, full holds off every beat until the back end
// takes a row. Each stored row then passes through the back end in order:
// the bit-serial row-mean divide, the ring store and window update, and the
// analysis step, which runs the same divider again for the window average.
// The end of an image adds up to half_window further analysis steps, then
// the summary beat. Results wait in a four-entry output queue, so a stalled
// consumer only stops the back end once that queue is full.
module strip_profile_peak_detector_top
  import spd_pkg::*;
#(
  parameter int STRIP_MAX       = STRIP_MAX_DEF,
  parameter int HALF_WINDOW_MAX = HALF_WINDOW_MAX_DEF,
  parameter int ROWS_MAX        = ROWS_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            pixel_i,
  input  logic                  row_end_i,
  input  logic                  image_end_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            kind_o,
  output logic [ROW_W-1:0]      peak_row_o,
  output logic [VAL_W-1:0]      peak_value_o,
  output logic [ROW_W-1:0]      valley_row_o,
  output logic [VAL_W-1:0]      valley_value_o,
  output logic [ROW_W-1:0]      rise_row_o,
  output logic [VAL_W-1:0]      rise_value_o,
  output logic [ROW_W-1:0]      fall_row_o,
  output logic [VAL_W-1:0]      fall_value_o,
  output logic                  last_o
);

  `include "strip_profile_peak_detector_top_macros.svh"

  logic [SW_W-1:0] strip_width_q;
  logic [HW_W-1:0] half_window_q;

  logic     accept;
  logic     q_push, q_full, q_pop, q_empty;
  row_ent_t q_din, q_dout;
  logic     res_push, res_full;
  res_t     res_rec, res_dout;

  // Configuration registers are plain write-only registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_width_q <= SW_RESET;
      half_window_q <= HW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_STRIP_WIDTH: strip_width_q <= cfg_wdata_i[SW_W-1:0];
        CFG_HALF_WINDOW: half_window_q <= cfg_wdata_i[HW_W-1:0];
        default: begin
          strip_width_q <= strip_width_q;
        end
      endcase
    end
  end

  // The input side refuses a beat only while the row queue is full.
  assign full   = q_full;
  assign accept = push && !full;

  spd_front #(.ROWS_MAX(ROWS_MAX)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pixel_i     (pixel_i),
    .row_end_i   (row_end_i),
    .image_end_i (image_end_i),
    .q_push_o    (q_push),
    .q_ent_o     (q_din)
  );

  spd_fifo #(.W($bits(row_ent_t)), .DEPTH(QUEUE_DEPTH)) u_row_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .empty_o (q_empty)
  );

  spd_back #(
    .STRIP_MAX       (STRIP_MAX),
    .HALF_WINDOW_MAX (HALF_WINDOW_MAX),
    .ROWS_MAX        (ROWS_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_ent_i       (q_dout),
    .q_pop_o       (q_pop),
    .strip_width_i (strip_width_q),
    .half_window_i (half_window_q),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_rec)
  );

  spd_fifo #(.W($bits(res_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .din_i   (res_rec),
    .full_o  (res_full),
    .pop_i   (pop),
    .dout_o  (res_dout),
    .empty_o (empty)
  );

  assign kind_o         = res_dout.kind;
  assign peak_row_o     = res_dout.peak_row;
  assign peak_value_o   = res_dout.peak_value;
  assign valley_row_o   = res_dout.valley_row;
  assign valley_value_o = res_dout.valley_value;
  assign rise_row_o     = res_dout.rise_row;
  assign rise_value_o   = res_dout.rise_value;
  assign fall_row_o     = res_dout.fall_row;
  assign fall_value_o   = res_dout.fall_value;
  assign last_o         = res_dout.last;

  // A row is never pushed into a full row queue, since full stalls the beat.
  `SPD_ASSERT_NEVER(a_row_q_overflow, q_push && q_full, "row queue overflow")
  // The back end only offers a result when the output queue has room.
  `SPD_ASSERT_NEVER(a_res_q_overflow, res_push && res_full, "result queue overflow")
  // Every summary record closes the results of its input beat.
  `SPD_ASSERT_IMPL(a_summary_last, res_push && (res_rec.kind == KIND_SUMMARY),
                   res_rec.last, "summary record without last")

endmodule

// ===== sim/strip_profile_peak_detector_checker.sv =====
// ----------------------------------------------------------------------------
// Strip profile peak detector checker
// Watches the configuration, pixel and result channels of the detector,
// predicts every result beat from the accepted pixels and compares them.
// ----------------------------------------------------------------------------
module strip_profile_peak_detector_checker
  import spd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push_i,
  input  logic                  full_i,
  input  logic [7:0]            pixel_i,
  input  logic                  row_end_i,
  input  logic                  image_end_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  logic [1:0]            kind_i,
  input  logic [ROW_W-1:0]      peak_row_i,
  input  logic [VAL_W-1:0]      peak_value_i,
  input  logic [ROW_W-1:0]      valley_row_i,
  input  logic [VAL_W-1:0]      valley_value_i,
  input  logic [ROW_W-1:0]      rise_row_i,
  input  logic [VAL_W-1:0]      rise_value_i,
  input  logic [ROW_W-1:0]      fall_row_i,
  input  logic [VAL_W-1:0]      fall_value_i,
  input  logic                  last_i,
  output int                    pending_o,
  output int                    results_o,
  output int                    errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 2 * HALF_WINDOW_MAX_DEF + 1;

  res_t expected_beats[$];

  // Configuration copies and the detector state.
  int strip_width, half_window;
  int row_sum, row_cnt, win_sum, win_cnt, win_w;
  int profile[RING];
  bit seeking, have_peak;
  int pk_row, pk_val, vl_row, vl_val, rs_row, rs_val, prof_min, prof_max;

  function automatic void add_beat(kind_e k, int pr, int pv, int vr, int vv,
                                   int rr, int rv, int fr, int fv);
    res_t b;
    b.kind = k;
    b.peak_row = pr[ROW_W-1:0];
    b.peak_value = pv[VAL_W-1:0];
    b.valley_row = vr[ROW_W-1:0];
    b.valley_value = vv[VAL_W-1:0];
    b.rise_row = rr[ROW_W-1:0];
    b.rise_value = rv[VAL_W-1:0];
    b.fall_row = fr[ROW_W-1:0];
    b.fall_value = fv[VAL_W-1:0];
    b.last = 1'b0;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic void clear_image();
    row_sum = 0; row_cnt = 0; win_sum = 0; win_cnt = 0;
    seeking = 0; have_peak = 0;
    pk_row = 0; pk_val = 0; vl_row = 0; vl_val = 0; rs_row = 0; rs_val = 0;
    prof_min = 255; prof_max = 0;
  endfunction

  // One step of the min/max search for profile row i.
  function automatic void search_row(int i, bit at_last);
    int y, avg;
    y = profile[i % RING];
    avg = (win_cnt != 0) ? win_sum / win_cnt : 0;
    if (i == 0) begin
      pk_row = 0; vl_row = 0; rs_row = 0;
      pk_val = y; vl_val = y; rs_val = y;
    end
    if (!seeking) begin
      // The last row of the image always counts as a rise.
      if (y > avg || at_last) begin
        if (have_peak) add_beat(KIND_VALLEY, 0, 0, vl_row, vl_val, 0, 0, 0, 0);
        rs_row = i; rs_val = y;
        seeking = 1;
        pk_row = i; pk_val = y;
      end else if (y < vl_val) begin
        vl_val = y; vl_row = i;
      end
    end else begin
      if (y < avg) begin
        add_beat(KIND_PEAK, pk_row, pk_val, vl_row, vl_val, rs_row, rs_val, i, y);
        have_peak = 1;
        seeking = 0;
        vl_val = y; vl_row = i;
      end else if (y > pk_val) begin
        pk_val = y; pk_row = i;
      end
    end
  endfunction

  function automatic void close_row();
    int dv, q, y, r;
    dv = strip_width;
    if (dv == 0) dv = 1;
    if (dv > STRIP_MAX_DEF) dv = STRIP_MAX_DEF;
    q = row_sum / dv;
    y = (q >= 256) ? 0 : 256 - q;
    row_sum = 0;
    r = row_cnt;
    // The window size is latched when the first row of an image ends.
    if (r == 0) begin
      win_w = half_window;
      if (win_w < 1) win_w = 1;
      if (win_w > HALF_WINDOW_MAX_DEF) win_w = HALF_WINDOW_MAX_DEF;
    end
    profile[r % RING] = y;
    if (y < prof_min) prof_min = y;
    if (y > prof_max) prof_max = y;
    win_sum += y;
    win_cnt++;
    if (r >= 2 * win_w) begin
      win_sum -= profile[(r - 2 * win_w) % RING];
      win_cnt--;
    end
    row_cnt = r + 1;
    if (r >= win_w) search_row(r - win_w, 0);
  endfunction

  function automatic void flush_tail();
    int r, i;
    if (row_cnt == 0) return;
    r = row_cnt - 1;
    i = (r + 1 > win_w) ? r + 1 - win_w : 0;
    for (; i <= r; i++) begin
      if (i >= win_w) begin
        win_sum -= profile[(i - win_w) % RING];
        win_cnt--;
      end
      search_row(i, i == r);
    end
  endfunction

  function automatic void take_pixel(int pix, bit re, bit ie);
    int n_prior;
    n_prior = expected_beats.size();
    row_sum += pix;
    if (row_sum > 20'hFFFFF) row_sum = 20'hFFFFF;
    if (re || ie) begin
      // Rows past the limit are summed and dropped.
      if (row_cnt < ROWS_MAX_DEF) close_row();
      else row_sum = 0;
    end
    if (ie) begin
      flush_tail();
      add_beat(KIND_SUMMARY, 0, prof_max, 0, prof_min, 0, 0, 0, 0);
      clear_image();
    end
    if (expected_beats.size() > n_prior)
      expected_beats[expected_beats.size() - 1].last = 1'b1;
  endfunction

  function automatic void cmp(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      strip_width = SW_RESET;
      half_window = HW_RESET;
      win_w = HW_RESET;
      foreach (profile[k]) profile[k] = 0;
      clear_image();
      expected_beats.delete();
      results_o <= 0;
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_STRIP_WIDTH) strip_width = cfg_wdata_i & 13'h1FFF;
        else half_window = cfg_wdata_i & 6'h3F;
      end
      if (push_i && !full_i) take_pixel(pixel_i, row_end_i, image_end_i);
      if (pop_i && !empty_i) begin
        results_o <= results_o + 1;
        if (expected_beats.size() == 0) begin
          $error("result beat with no expectation waiting");
          errors_o++;
        end else begin
          e = expected_beats.pop_front();
          cmp("kind", e.kind, kind_i);
          cmp("peak_row", e.peak_row, peak_row_i);
          cmp("peak_value", e.peak_value, peak_value_i);
          cmp("valley_row", e.valley_row, valley_row_i);
          cmp("valley_value", e.valley_value, valley_value_i);
          cmp("rise_row", e.rise_row, rise_row_i);
          cmp("rise_value", e.rise_value, rise_value_i);
          cmp("fall_row", e.fall_row, fall_row_i);
          cmp("fall_value", e.fall_value, fall_value_i);
          cmp("last", e.last, last_i);
        end
      end
    end
    pending_o <= expected_beats.size();
  end

endmodule

// ===== sim/strip_profile_peak_detector_top_test.sv =====
// ----------------------------------------------------------------------------
// Strip profile peak detector test
// Streams directed and random strip images into the detector with random
// gaps on both sides, while a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module strip_profile_peak_detector_top_test;
  import spd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [0:0]            cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  push, full, empty, pop;
  logic [7:0]            pixel_i;
  logic                  row_end_i, image_end_i;
  logic [1:0]            kind_o;
  logic [ROW_W-1:0]      peak_row_o, valley_row_o, rise_row_o, fall_row_o;
  logic [VAL_W-1:0]      peak_value_o, valley_value_o, rise_value_o, fall_value_o;
  logic                  last_o;
  int                    pending, results, errors;

  int  pixels_sent;
  longint cycles;

  always #6 clk_i = ~clk_i;

  strip_profile_peak_detector_top u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .push, .full, .pixel_i, .row_end_i, .image_end_i,
    .empty, .pop, .kind_o, .peak_row_o, .peak_value_o, .valley_row_o,
    .valley_value_o, .rise_row_o, .rise_value_o, .fall_row_o, .fall_value_o,
    .last_o
  );

  strip_profile_peak_detector_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .push_i(push), .full_i(full), .pixel_i, .row_end_i, .image_end_i,
    .empty_i(empty), .pop_i(pop), .kind_i(kind_o), .peak_row_i(peak_row_o),
    .peak_value_i(peak_value_o), .valley_row_i(valley_row_o),
    .valley_value_i(valley_value_o), .rise_row_i(rise_row_o),
    .rise_value_i(rise_value_o), .fall_row_i(fall_row_o),
    .fall_value_i(fall_value_o), .last_i(last_o),
    .pending_o(pending), .results_o(results), .errors_o(errors)
  );

  // Watchdog: the slowest legal run of this test is far below this limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 500_000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: a random stall before each beat, then pop stays high until
  // a beat is taken. Reading empty right after the edge gives its value at
  // that edge, since the block updates it in the same step only later.
  initial begin
    int gap;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Registers are only written while the block is idle.
  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Sends one pixel beat; called at a falling edge and returns at one.
  task automatic send_pixel(int pix, bit re, bit ie);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push        <= 1'b1;
    pixel_i     <= pix[7:0];
    row_end_i   <= re;
    image_end_i <= ie;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    pixels_sent++;
  endtask

  // Called at a falling edge: drops push at once, waits until every
  // predicted beat is out, then lets the back end settle.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  // One image with a bumpy darkness profile: the level jumps every few rows
  // so the moving average is crossed both ways. The image end sometimes
  // comes without a row end on the same beat.
  task automatic send_image(int rows, int width);
    int level, pix, run;
    run = 0;
    level = 0;
    for (int r = 0; r < rows; r++) begin
      if (run == 0) begin
        level = $urandom_range(0, 255);
        run = $urandom_range(1, 5);
      end
      run--;
      for (int p = 0; p < width; p++) begin
        pix = level + $urandom_range(0, 40) - 20;
        if (pix < 0) pix = 0;
        if (pix > 255) pix = 255;
        if ($urandom_range(0, 15) == 0) pix = $urandom_range(0, 255);
        if (r == rows - 1 && p == width - 1)
          send_pixel(pix, $urandom_range(0, 1), 1'b1);
        else
          send_pixel(pix, p == width - 1, 1'b0);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = CFG_STRIP_WIDTH;
    cfg_wdata_i = '0;
    push        = 1'b0;
    pixel_i     = '0;
    row_end_i   = 1'b0;
    image_end_i = 1'b0;
    pixels_sent = 0;
    cycles      = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. One pixel per row first: black and white extremes, a
    // two-pixel white row whose mean overflows to a zero profile value, and
    // an image end that arrives without a row end.
    write_reg(CFG_STRIP_WIDTH, 1);
    write_reg(CFG_HALF_WINDOW, 1);
    send_pixel(0, 1'b1, 1'b0);
    send_pixel(255, 1'b1, 1'b0);
    send_pixel(255, 1'b0, 1'b0);
    send_pixel(255, 1'b1, 1'b0);
    send_pixel(128, 1'b1, 1'b0);
    send_pixel(7, 1'b0, 1'b1);
    // A single-row image: its only row is also the forced rise.
    send_pixel(200, 1'b1, 1'b1);
    wait_idle();
    write_reg(CFG_STRIP_WIDTH, 3);
    send_image(3, 3);
    wait_idle();

    // A strip width above the supported maximum and a zero half window.
    write_reg(CFG_STRIP_WIDTH, 8191);
    write_reg(CFG_HALF_WINDOW, 0);
    send_image(4, 2);
    wait_idle();

    // A zero strip width and the largest half window value.
    write_reg(CFG_STRIP_WIDTH, 0);
    write_reg(CFG_HALF_WINDOW, 63);
    send_image(5, 1);
    wait_idle();

    // The largest legal settings on a short image.
    write_reg(CFG_STRIP_WIDTH, 4096);
    write_reg(CFG_HALF_WINDOW, 32);
    send_image(6, 2);
    wait_idle();

    // Random part: small strips and short images so that peaks come often.
    while (pixels_sent < 160) begin
      write_reg(CFG_STRIP_WIDTH, $urandom_range(1, 3));
      write_reg(CFG_HALF_WINDOW,
                ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 6));
      send_image($urandom_range(4, 20), $urandom_range(1, 2));
      wait_idle();
    end

    $display("Sent %0d pixel beats in directed, register-extreme and random images;",
             pixels_sent);
    $display("checked %0d result beats with random stalls on both sides.", results);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
